### sv/rripc_pkg.sv
// Shared types, codes and constants of the RRIP replacement core.
package rripc_pkg;

  // Field widths fixed by the interface.
  localparam int SET_IDX_W = 11;
  localparam int WAY_W     = 4;
  localparam int PC_W      = 64;
  localparam int THR_W     = 3;
  localparam int CNT_W     = 3;
  localparam int RR_W      = 2;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 2;

  // Default geometry.
  localparam int NUM_SETS_DEF         = 2048;
  localparam int NUM_WAYS_DEF         = 16;
  localparam int PC_TABLE_ENTRIES_DEF = 4096;

  // Action codes.
  localparam logic ACT_VICTIM = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // Re-reference values.
  localparam logic [RR_W-1:0] RR_HIT  = 2'd0;
  localparam logic [RR_W-1:0] RR_NEAR = 2'd1;
  localparam logic [RR_W-1:0] RR_FAR  = 2'd2;
  localparam logic [RR_W-1:0] RR_MAX  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_ZERO = 3'd0;
  localparam logic [CNT_W-1:0] CNT_MAX  = 3'd7;

  // Register map.
  localparam logic [APB_AW-1:0] ADDR_HOT_THRESHOLD = 2'd0;
  localparam logic [THR_W-1:0]  HOT_THRESHOLD_RST  = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture an accepted transaction
    logic read;    // read the set row and the reuse counter
    logic commit;  // write back and, for a victim request, present the result
    logic clear;   // one step of the post-reset clearing sweep
  } rripc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reduce_done;  // set and counter indexes are ready
    logic clear_last;   // final step of the clearing sweep
    logic is_victim;    // held transaction is a victim request
    logic out_busy;     // output register holds a result that is not taken
  } rripc_status_t;

endpackage

### sv/rrip_pc_insertion_replacement_core.sv
// Top level of the RRIP replacement core with PC-guided insertion.
//
// The block keeps a 2-bit re-reference value for every way of every set and a
// small table of 3-bit reuse counters indexed by the PC modulo PC_TABLE_ENTRIES.
// Input transactions arrive on in_valid/in_stall; a victim request (action 0)
// yields one transaction on out_valid/out_stall carrying victim_way, while an
// update (action 1) yields none. The hot_threshold register sits at byte
// address 0 of the APB port and may only be written while the block is idle.
// Once accepted, a transaction reads the set row and reuse counter in the
// lookup state and evaluates and writes them back in the evaluation state,
// which also accepts the next transaction, so a new transaction can be taken
// before the last is through; a victim is registered into the output register
// when its evaluation commits. Where NUM_SETS or PC_TABLE_ENTRIES is not a
// power of two, the index is reduced 16 bits at a time, and the lookup waits
// for both indexes. After reset the block sweeps both memories, one row a
// cycle, over max(NUM_SETS, PC_TABLE_ENTRIES) rows (4096 by default) with
// in_stall high. When the receiver stalls, the result is held in the output
// register; a further update is still taken, and a further victim request
// waits in evaluation until the held result has gone.
module rrip_pc_insertion_replacement_core #(
  parameter int NUM_SETS         = rripc_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS         = rripc_pkg::NUM_WAYS_DEF,
  parameter int PC_TABLE_ENTRIES = rripc_pkg::PC_TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rripc_pkg::APB_AW-1:0]     paddr,
  input  logic [rripc_pkg::APB_DW-1:0]     pwdata,
  output logic [rripc_pkg::APB_DW-1:0]     prdata,
  output logic                             pready,
  // Request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             action,
  input  logic [rripc_pkg::SET_IDX_W-1:0]  set_index,
  input  logic [rripc_pkg::WAY_W-1:0]      way,
  input  logic [rripc_pkg::PC_W-1:0]       pc,
  input  logic                             hit,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rripc_pkg::WAY_W-1:0]      victim_way
);
  import rripc_pkg::*;

  rripc_cmd_t    cmd;
  rripc_status_t status;
  logic [THR_W-1:0] hot_threshold;

  // The configuration port never waits; a register write lands on the
  // access phase of the transaction.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_threshold <= HOT_THRESHOLD_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_HOT_THRESHOLD) begin
      hot_threshold <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_HOT_THRESHOLD) begin
      prdata = APB_DW'(hot_threshold);
    end
  end

  // The controller sequences each transaction; the datapath owns the memories,
  // the index reduction and the output register.
  rripc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  rripc_dp #(
    .NUM_SETS         (NUM_SETS),
    .NUM_WAYS         (NUM_WAYS),
    .PC_TABLE_ENTRIES (PC_TABLE_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .action        (action),
    .set_index     (set_index),
    .way           (way),
    .pc            (pc),
    .hit           (hit),
    .hot_threshold (hot_threshold),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .victim_way    (victim_way)
  );

endmodule

### sv/rripc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rripc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/rripc_mod.sv
// Remainder of a value by a constant: a mask for powers of two, else a reciprocal multiplication.
module rripc_mod #(
  parameter int IN_W  = 11,
  parameter int MOD   = 2048,
  parameter int OUT_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [IN_W-1:0]  value,
  output logic [OUT_W-1:0] rem,
  output logic             done
);

  localparam bit IS_POW2 = ((MOD & (MOD - 1)) == 0);

  generate
    if (IS_POW2) begin : g_mask
      localparam logic [IN_W-1:0] MASK = IN_W'(MOD - 1);
      logic [IN_W-1:0] val_q;

      always_ff @(posedge clk) begin
        if (start) begin
          val_q <= value;
        end
      end

      assign rem  = OUT_W'(val_q & MASK);
      assign done = 1'b1;
    end else begin : g_recip
      // Horner reduction over 16-bit chunks from the top, for MOD up to 65536. Each
      // chunk takes a reciprocal multiplication for a quotient estimate that is at most
      // one short, then one compare and subtract, each in its own phase of the chunk.
      localparam int CH_W   = 16;
      localparam int N_CH   = (IN_W + CH_W - 1) / CH_W;
      localparam int PAD_W  = N_CH * CH_W;
      localparam int X_W    = 2 * CH_W;
      localparam int RCP_W  = 31;
      localparam int STEP_W = $clog2(N_CH + 1);
      localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << X_W) / MOD);
      localparam logic [CH_W-1:0]  MOD_C = CH_W'(MOD);
      localparam logic [CH_W:0]    MOD_X = (CH_W + 1)'(MOD);

      logic [PAD_W-1:0]     sh;
      logic [CH_W-1:0]      r;
      logic [STEP_W-1:0]    steps;
      logic                 phase;
      logic [CH_W-1:0]      q_est;
      logic [X_W-1:0]       x;
      logic [X_W+RCP_W-1:0] prod;
      logic [X_W-1:0]       qm;
      logic [X_W-1:0]       diff;
      logic [CH_W:0]        r_est;

      assign x     = {r, sh[PAD_W-1 -: CH_W]};
      assign prod  = (X_W + RCP_W)'(x) * (X_W + RCP_W)'(RECIP);
      assign qm    = X_W'(q_est) * X_W'(MOD_C);
      assign diff  = x - qm;
      assign r_est = diff[CH_W:0];

      always_ff @(posedge clk) begin
        if (rst) begin
          steps <= '0;
          phase <= 1'b0;
        end else if (start) begin
          r     <= '0;
          sh    <= PAD_W'(value);
          steps <= STEP_W'(N_CH);
          phase <= 1'b0;
        end else if (steps != '0) begin
          if (!phase) begin
            q_est <= prod[X_W +: CH_W];
            phase <= 1'b1;
          end else begin
            r     <= (r_est >= MOD_X) ? CH_W'(r_est - MOD_X) : r_est[CH_W-1:0];
            sh    <= sh << CH_W;
            steps <= steps - 1'b1;
            phase <= 1'b0;
          end
        end
      end

      assign rem  = OUT_W'(r);
      assign done = (steps == '0);
    end
  endgenerate

endmodule

### sv/rripc_ctrl.sv
// Controller state machine of the RRIP replacement core.
module rripc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output rripc_pkg::rripc_cmd_t    cmd,
  input  rripc_pkg::rripc_status_t status
);
  import rripc_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_EVAL
  } state_t;

  state_t state, state_next;
  logic   can_commit;

  assign can_commit = !status.is_victim || !status.out_busy;

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (status.reduce_done) begin
          cmd.read   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          in_stall   = 1'b0;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_LOOKUP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_LOOKUP)
    else $error("accepted transaction did not enter lookup");
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> in_stall && !cmd.commit && !cmd.read)
    else $error("activity during clearing sweep");
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && status.is_victim |-> !status.out_busy)
    else $error("victim committed while output register busy");
`endif

endmodule

### sv/rripc_dp.sv
// Datapath of the RRIP replacement core: index reduction, memories, set evaluation.
module rripc_dp #(
  parameter int NUM_SETS         = rripc_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS         = rripc_pkg::NUM_WAYS_DEF,
  parameter int PC_TABLE_ENTRIES = rripc_pkg::PC_TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rripc_pkg::rripc_cmd_t            cmd,
  output rripc_pkg::rripc_status_t         status,
  input  logic                             action,
  input  logic [rripc_pkg::SET_IDX_W-1:0]  set_index,
  input  logic [rripc_pkg::WAY_W-1:0]      way,
  input  logic [rripc_pkg::PC_W-1:0]       pc,
  input  logic                             hit,
  input  logic [rripc_pkg::THR_W-1:0]      hot_threshold,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [rripc_pkg::WAY_W-1:0]      victim_way
);
  import rripc_pkg::*;

  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SLOT_W = $clog2(PC_TABLE_ENTRIES);
  localparam int WIDX_W = $clog2(NUM_WAYS);
  localparam int ROW_W  = NUM_WAYS * RR_W;
  localparam int CLR_N  = (NUM_SETS > PC_TABLE_ENTRIES) ? NUM_SETS : PC_TABLE_ENTRIES;
  localparam int CLR_W  = $clog2(CLR_N);

  typedef logic [NUM_WAYS-1:0][RR_W-1:0] row_t;

  // Held transaction.
  logic       action_q;
  logic [WAY_W-1:0] way_q;
  logic       hit_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action;
      way_q    <= way;
      hit_q    <= hit;
    end
  end

  // Index reduction.
  logic [SET_W-1:0]  set_rem;
  logic [SLOT_W-1:0] slot_rem;
  logic              set_done, slot_done;

  rripc_mod #(.IN_W(SET_IDX_W), .MOD(NUM_SETS), .OUT_W(SET_W)) u_set_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.load),
    .value (set_index),
    .rem   (set_rem),
    .done  (set_done)
  );

  rripc_mod #(.IN_W(PC_W), .MOD(PC_TABLE_ENTRIES), .OUT_W(SLOT_W)) u_pc_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.load),
    .value (pc),
    .rem   (slot_rem),
    .done  (slot_done)
  );

  // Clearing sweep after reset.
  logic [CLR_W-1:0] clr_cnt;
  logic             clr_sets, clr_slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign clr_sets  = ({1'b0, clr_cnt} < (CLR_W + 1)'(NUM_SETS));
  assign clr_slots = ({1'b0, clr_cnt} < (CLR_W + 1)'(PC_TABLE_ENTRIES));

  // Memories.
  row_t             row_rd, row_wr;
  logic             row_we;
  logic [SET_W-1:0] row_waddr;
  logic [CNT_W-1:0] cnt_rd, cnt_next, cnt_wr;
  logic             cnt_we;
  logic [SLOT_W-1:0] cnt_waddr;

  rripc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rrv_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wr),
    .re    (cmd.read),
    .raddr (set_rem),
    .rdata (row_rd)
  );

  rripc_ram #(.WIDTH(CNT_W), .DEPTH(PC_TABLE_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wr),
    .re    (cmd.read),
    .raddr (slot_rem),
    .rdata (cnt_rd)
  );

  // Set evaluation.
  logic [NUM_WAYS-1:0] at_max, at_far, at_near;
  logic                any_max;
  logic [RR_W-1:0]     top, age;
  row_t                aged, upd_row;
  logic [WIDX_W-1:0]   found;
  logic                way_ok;
  logic [RR_W-1:0]     ins_val;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      at_max[w]  = (row_rd[w] == RR_MAX);
      at_far[w]  = (row_rd[w] == RR_FAR);
      at_near[w] = (row_rd[w] == RR_NEAR);
    end
    any_max = |at_max;
    if (any_max) begin
      top = RR_MAX;
    end else if (|at_far) begin
      top = RR_FAR;
    end else if (|at_near) begin
      top = RR_NEAR;
    end else begin
      top = RR_HIT;
    end
    age = RR_MAX - top;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w] = row_rd[w] + age;
    end
    // Lowest way at the maximum after aging.
    found = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (aged[w] == RR_MAX) begin
        found = WIDX_W'(w);
      end
    end
  end

  assign cnt_next = (cnt_rd == CNT_MAX) ? CNT_MAX : cnt_rd + 1'b1;
  assign way_ok   = (int'(way_q) < NUM_WAYS);

  always_comb begin
    if (hit_q) begin
      ins_val = RR_HIT;
    end else if (cnt_next > hot_threshold) begin
      ins_val = RR_NEAR;
    end else begin
      ins_val = RR_FAR;
    end
    upd_row = row_rd;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (int'(way_q) == w) begin
        upd_row[w] = ins_val;
      end
    end
  end

  // Write selection.
  always_comb begin
    row_we    = 1'b0;
    row_waddr = set_rem;
    row_wr    = aged;
    cnt_we    = 1'b0;
    cnt_waddr = slot_rem;
    cnt_wr    = cnt_next;
    if (cmd.clear) begin
      row_we    = clr_sets;
      row_waddr = clr_cnt[SET_W-1:0];
      row_wr    = {NUM_WAYS{RR_MAX}};
      cnt_we    = clr_slots;
      cnt_waddr = clr_cnt[SLOT_W-1:0];
      cnt_wr    = CNT_ZERO;
    end else if (cmd.commit) begin
      if (action_q == ACT_VICTIM) begin
        row_we = !any_max;
      end else begin
        row_we = way_ok;
        row_wr = upd_row;
        cnt_we = 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && action_q == ACT_VICTIM) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && action_q == ACT_VICTIM) begin
      victim_way <= WAY_W'(found);
    end
  end

  assign status.reduce_done = set_done && slot_done;
  assign status.clear_last  = (clr_cnt == CLR_W'(CLR_N - 1));
  assign status.is_victim   = (action_q == ACT_VICTIM);
  assign status.out_busy    = out_valid && out_stall;

`ifndef SYNTHESIS
  a_out_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit && action_q == ACT_VICTIM))
    else $error("result appeared without a victim commit");
  a_read_indexes_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> set_done && slot_done)
    else $error("memory read before index reduction finished");
  a_victim_presented: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && action_q == ACT_VICTIM |=> out_valid)
    else $error("victim commit lost its result");
`endif

endmodule

### verif/rrip_pc_insertion_replacement_core_tb.sv
// Self-checking testbench for the RRIP replacement core with PC-guided insertion.
module rrip_pc_insertion_replacement_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rripc_pkg::*;

  // Geometry of the instance under test; the predictor is sized to match it.
  localparam int NUM_SETS         = NUM_SETS_DEF;
  localparam int NUM_WAYS         = NUM_WAYS_DEF;
  localparam int PC_TABLE_ENTRIES = PC_TABLE_ENTRIES_DEF;

  // The clearing sweep after reset and the long receiver hold-off both pass with no
  // accepted transaction, so the watchdog limit sits well above both.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int HOT_POOL       = 8;

  // One request transaction as it is driven on the payload ports.
  typedef struct packed {
    logic                 action;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_W-1:0]     way;
    logic [PC_W-1:0]      pc;
    logic                 hit;
  } cache_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic                 action    = ACT_VICTIM;
  logic [SET_IDX_W-1:0] set_index = '0;
  logic [WAY_W-1:0]     way       = '0;
  logic [PC_W-1:0]      pc        = '0;
  logic                 hit       = 1'b0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [WAY_W-1:0] victim_way;

  rrip_pc_insertion_replacement_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .set_index  (set_index),
    .way        (way),
    .pc         (pc),
    .hit        (hit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .victim_way (victim_way)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted copy of the replacement state and the threshold register.
  logic [RR_W-1:0]  rrv_table   [NUM_SETS*NUM_WAYS];
  logic [CNT_W-1:0] reuse_table [PC_TABLE_ENTRIES];
  logic [THR_W-1:0] hot_thr_model;

  cache_req_t       pending_reqs[$];
  logic [WAY_W-1:0] expected_victims[$];

  int  errors        = 0;
  int  tx_idle_pct   = 0;
  int  rx_idle_pct   = 0;
  int  hold_requests = 0;
  int  holds_taken   = 0;
  int  hold_left     = 0;
  int  stuck_cycles  = 0;
  logic req_fire     = 1'b0;

  // Pools of hot sets and PCs, so that random traffic keeps returning to the same rows
  // and counters. The second half of the PC pool aliases the first in the low bits.
  logic [SET_IDX_W-1:0] hot_sets [HOT_POOL];
  logic [PC_W-1:0]      hot_pcs  [2*HOT_POOL];
  int                   n_hot_sets = HOT_POOL;

  // Applies one accepted transaction to the predicted state. A victim request queues
  // the way that the block must return; an update queues nothing.
  function automatic void predict_request(input cache_req_t r);
    int unsigned      base;
    int unsigned      slot;
    int unsigned      found;
    logic [RR_W-1:0]  top;
    logic [RR_W-1:0]  age;
    logic [CNT_W-1:0] cnt;
    base = (int'(r.set_index) % NUM_SETS) * NUM_WAYS;
    if (r.action == ACT_VICTIM) begin
      found = NUM_WAYS;
      for (int w = NUM_WAYS - 1; w >= 0; w--)
        if (rrv_table[base + w] == RR_MAX) found = w;
      if (found == NUM_WAYS) begin
        // No way is at the distant value: age the whole row until one gets there.
        top = '0;
        for (int w = 0; w < NUM_WAYS; w++)
          if (rrv_table[base + w] > top) top = rrv_table[base + w];
        age = RR_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++)
          rrv_table[base + w] = rrv_table[base + w] + age;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
          if (rrv_table[base + w] == RR_MAX) found = w;
        if (found == NUM_WAYS) found = 0;
      end
      expected_victims.push_back(WAY_W'(found));
    end else begin
      // The counter table is tagless, so PCs that share low bits share a counter.
      slot = int'(r.pc % PC_W'(PC_TABLE_ENTRIES));
      cnt  = reuse_table[slot];
      if (cnt != CNT_MAX) cnt = cnt + 1'b1;
      reuse_table[slot] = cnt;
      if (int'(r.way) < NUM_WAYS) begin
        if (r.hit)
          rrv_table[base + r.way] = RR_HIT;
        else if (cnt > hot_thr_model)
          rrv_table[base + r.way] = RR_NEAR;
        else
          rrv_table[base + r.way] = RR_FAR;
      end
    end
  endfunction

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic cache_req_t make_req(input logic act, input int set_i, input int way_i,
                                          input logic [PC_W-1:0] pc_v, input logic hit_v);
    cache_req_t r;
    r.action    = act;
    r.set_index = SET_IDX_W'(set_i);
    r.way       = WAY_W'(way_i);
    r.pc        = pc_v;
    r.hit       = hit_v;
    return r;
  endfunction

  function automatic void refill_pools(input int n_sets);
    n_hot_sets = n_sets;
    for (int i = 0; i < HOT_POOL; i++) begin
      hot_sets[i]           = SET_IDX_W'($urandom);
      hot_pcs[i]            = {$urandom, $urandom};
      hot_pcs[i + HOT_POOL] = {$urandom, 20'($urandom_range(0, 1048575)), hot_pcs[i][11:0]};
    end
  endfunction

  // Mostly updates and victim requests on a few hot sets with recurring PCs, so that rows
  // fill up and get aged; the rest lands anywhere with arbitrary PCs.
  function automatic cache_req_t random_request();
    cache_req_t r;
    r.action = ($urandom_range(0, 99) < 40) ? ACT_VICTIM : ACT_UPDATE;
    if ($urandom_range(0, 99) < 80)
      r.set_index = hot_sets[$urandom_range(0, n_hot_sets - 1)];
    else
      r.set_index = SET_IDX_W'($urandom);
    r.way = WAY_W'($urandom);
    r.hit = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 70)
      r.pc = hot_pcs[$urandom_range(0, 2*HOT_POOL - 1)];
    else
      r.pc = {$urandom, $urandom};
    return r;
  endfunction

  // Request driver: a new transaction is offered only once the previous one has been taken,
  // so the payload stays put while the block stalls it.
  always @(negedge clk) begin : drive_requests
    cache_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt       = pending_reqs.pop_front();
        in_valid  <= 1'b1;
        action    <= nxt.action;
        set_index <= nxt.set_index;
        way       <= nxt.way;
        pc        <= nxt.pc;
        hit       <= nxt.hit;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off whenever the sequence asks for
  // it, during which the block has to fill up and push back on its input.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_requests != holds_taken) begin
      holds_taken = holds_taken + 1;
      hold_left   = LONG_HOLD - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Monitor: results are checked before the request of the same edge is predicted, since
  // a result can never belong to a request taken at that very edge.
  always @(posedge clk) begin : watch_channels
    cache_req_t r;
    logic [WAY_W-1:0] exp_way;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_victims.size() == 0) begin
          note_failure($sformatf("Unexpected result transaction: victim_way %0d", victim_way));
        end else begin
          exp_way = expected_victims.pop_front();
          if (victim_way !== exp_way)
            note_failure($sformatf("victim_way mismatch: expected %0d, actual %0d",
                                   exp_way, victim_way));
        end
      end
      if (in_valid && !in_stall) begin
        r.action    = action;
        r.set_index = set_index;
        r.way       = way;
        r.pc        = pc;
        r.hit       = hit;
        predict_request(r);
      end
    end
    req_fire <= in_valid && !in_stall;
  end

  // Watchdog on progress: any accepted transaction on either channel or the APB port
  // restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Writes the threshold register through a setup and an access phase; random upper bits
  // check that only the low three bits count.
  task automatic write_hot_threshold(input logic [THR_W-1:0] thr);
    logic [APB_DW-1:0] data;
    data = {$urandom} & ~APB_DW'(7) | APB_DW'(thr);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_HOT_THRESHOLD;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    hot_thr_model = data[THR_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Sender stays quiet until every request is out and every expected result has come,
  // then lets the pipeline settle, since an update can still be in flight.
  task automatic wait_for_drain();
    while (pending_reqs.size() != 0 || in_valid || expected_victims.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [THR_W-1:0] thr, input int n_items, input int tx_pct,
                           input int rx_pct, input int n_sets, input bit long_hold);
    write_hot_threshold(thr);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    refill_pools(n_sets);
    for (int i = 0; i < n_items / 2; i++) pending_reqs.push_back(random_request());
    if (long_hold) begin
      hold_requests++;
      // A run of victim requests on one set so the output register fills at once.
      for (int i = 0; i < 20; i++)
        pending_reqs.push_front(make_req(ACT_VICTIM, hot_sets[0], 0, '0, 1'b0));
    end
    // Pause the sender mid-phase until the block has given back everything.
    wait_for_drain();
    for (int i = n_items / 2; i < n_items; i++) pending_reqs.push_back(random_request());
    wait_for_drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_SETS*NUM_WAYS; i++) rrv_table[i] = RR_MAX;
    for (int i = 0; i < PC_TABLE_ENTRIES; i++) reuse_table[i] = CNT_ZERO;
    hot_thr_model = HOT_THRESHOLD_RST;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // The clearing sweep holds in_stall high; wait for it to end before anything else.
    while (in_stall !== 1'b0) @(posedge clk);

    // Directed part, with the reset threshold. Victims on fresh rows at both ends of the
    // set range carry all-ones in the fields that a victim request ignores.
    pending_reqs.push_back(make_req(ACT_VICTIM, 0, 15, '1, 1'b1));
    pending_reqs.push_back(make_req(ACT_VICTIM, NUM_SETS - 1, 15, '1, 1'b1));
    // Fill every way of one set with PCs that alias onto a single counter, which climbs
    // past the threshold and then saturates; the first way is a hit instead.
    for (int w = 0; w < NUM_WAYS; w++)
      pending_reqs.push_back(make_req(ACT_UPDATE, 5, w,
                                      {$urandom, 20'($urandom_range(0, 1048575)), 12'hABC},
                                      w == 0));
    // No way of that set is at the distant value now, so the row must be aged.
    pending_reqs.push_back(make_req(ACT_VICTIM, 5, 0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_VICTIM, 5, 0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_UPDATE, NUM_SETS - 1, NUM_WAYS - 1, '1, 1'b1));
    pending_reqs.push_back(make_req(ACT_UPDATE, 0, 0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_VICTIM, NUM_SETS - 1, 0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_VICTIM, 0, 0, '0, 1'b0));
    wait_for_drain();

    // Random phases over several thresholds, the extremes among them: first the sender
    // idles lightly and the receiver heavily, then the reverse, then neither.
    run_phase(3'd0, 550, 28, 75, 6, 1'b0);
    run_phase(3'd7, 550, 75, 28, 4, 1'b0);
    run_phase(3'd6, 300, 0, 0, 3, 1'b1);
    run_phase(THR_W'($urandom_range(0, 7)), 300, 0, 0, 8, 1'b0);

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_victims.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
